// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the RTL of the strip clock renderer.
// Needs clk_i and rst_ni in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, off while reset is asserted.
`define ASSERT_CLK(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

// Implication checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("assertion failed");

`endif

// ===== rtl/core/sscr_pkg.sv =====
// Types, constants and digit tables of the strip clock renderer.
// No dependencies; imported by the top level.
package sscr_pkg;

  localparam int unsigned STRIP_LENGTH = 300;
  localparam int unsigned DIGIT_LEDS   = 288;

  localparam logic [8:0] COLON_LEFT_LED  = 9'd22;
  localparam logic [8:0] COLON_RIGHT_LED = 9'd103;
  localparam logic [8:0] COLON_MID_LED   = 9'd202;

  // Configuration register indexes
  localparam logic [2:0] REG_HOUR_COLOUR      = 3'd0;
  localparam logic [2:0] REG_MINUTE_COLOUR    = 3'd1;
  localparam logic [2:0] REG_SEPARATOR_COLOUR = 3'd2;
  localparam logic [2:0] REG_DOWNLIGHT_COLOUR = 3'd3;
  localparam logic [2:0] REG_SEPARATOR_STYLE  = 3'd4;
  localparam logic [2:0] REG_DOWNLIGHTS_ON    = 3'd5;
  localparam logic [2:0] REG_DISPLAY_ON       = 3'd6;

  // Separator styles
  localparam logic [1:0] SEP_DUAL   = 2'd0;
  localparam logic [1:0] SEP_SINGLE = 2'd1;

  localparam logic [23:0] RST_HOUR_COLOUR      = 24'hFF0000;
  localparam logic [23:0] RST_MINUTE_COLOUR    = 24'h008000;
  localparam logic [23:0] RST_SEPARATOR_COLOUR = 24'hFFFF00;
  localparam logic [23:0] RST_DOWNLIGHT_COLOUR = 24'hFFFFFF;

  localparam logic [5:0] NO_SEG = 6'h3F;

  localparam logic [6:0] DIGIT_PATTERN [10] = '{
    7'h77, 7'h24, 7'h5D, 7'h6D, 7'h2E, 7'h6B, 7'h7B, 7'h25, 7'h7F, 7'h6F
  };

  localparam logic [5:0] PLACEMENT [4][7] = '{
    '{NO_SEG, NO_SEG, 6'd14, NO_SEG, NO_SEG, 6'd15, NO_SEG},
    '{6'd12, 6'd18, 6'd21, 6'd19, 6'd17, 6'd20, 6'd1},
    '{6'd10, 6'd24, 6'd27, 6'd25, 6'd23, 6'd26, 6'd3},
    '{6'd8,  6'd30, 6'd7,  6'd31, 6'd29, 6'd6,  6'd5}
  };

  typedef struct packed {
    logic [8:0] pixel_index;
    logic [4:0] hour_value;
    logic [5:0] minute_value;
    logic       separator_phase;
  } in_word_t;

  typedef struct packed {
    logic [8:0]  pixel_out;
    logic [23:0] pixel_colour;
  } out_word_t;

  // Strip segments lit by digit d at digit position p; nothing for d above 9.
  function automatic logic [31:0] digit_seg_mask(input logic [1:0] p, input logic [3:0] d);
    logic [31:0] mask;
    logic [5:0]  seg;
    mask = '0;
    if (d <= 4'd9) begin
      for (int i = 0; i < 7; i++) begin
        seg = PLACEMENT[p][i];
        if (DIGIT_PATTERN[d][i] && seg != NO_SEG) begin
          mask[seg[4:0]] = 1'b1;
        end
      end
    end
    return mask;
  endfunction

endpackage

// ===== rtl/core/seven_segment_strip_clock_render_unit.sv =====
// Per-LED colour renderer of a four-digit seven-segment strip clock.
// Depends on sscr_pkg and assert_macros.svh.
//
// Usage: each input word carries an LED position, the hour (24-hour form),
// the minute and the colon blink phase; each output word echoes the position
// with its 0xRRGGBB colour. Both channels use valid/ready.
// The datapath is three register stages: decode (segment number, 12-hour
// digit, minute digits, LED class), segment match against the digit masks,
// and colour selection into the output register. A word passes through the
// decode, match and output registers in turn, and one word is taken every
// cycle while the receiver does not stall.
// When the receiver stalls, each stage holds its word while the stage ahead
// is full, so up to three words wait inside and input ready drops only when
// all three are full. Reset empties the pipeline and loads the colour and
// mode registers with their defaults: red hours, green minutes, yellow colon,
// white downlights, dual colon, downlights off, display on.
// Configuration writes take effect at once and belong to idle periods.
`include "assert_macros.svh"

module seven_segment_strip_clock_render_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_addr_i,
  input  logic [23:0]         cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  sscr_pkg::in_word_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output sscr_pkg::out_word_t out_data_o
);
  import sscr_pkg::*;

  localparam logic [10:0] STRIP_LEN_W  = 11'(STRIP_LENGTH);
  localparam logic [10:0] DIGIT_LEDS_W = 11'(DIGIT_LEDS);

  typedef struct packed {
    logic [8:0] idx;
    logic [4:0] seg;
    logic       blank;
    logic       down;
    logic       colon;
    logic       phase;
    logic [3:0] twelve;
    logic [2:0] tens;
    logic [3:0] units;
  } dec_t;

  typedef struct packed {
    logic [8:0] idx;
    logic       blank;
    logic       down;
    logic       colon;
    logic       phase;
    logic       hour_hit;
    logic       minute_hit;
  } match_t;

  // configuration registers
  logic [23:0] hour_colour_q, minute_colour_q, separator_colour_q, downlight_colour_q;
  logic [1:0]  separator_style_q;
  logic        downlights_on_q, display_on_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hour_colour_q      <= RST_HOUR_COLOUR;
      minute_colour_q    <= RST_MINUTE_COLOUR;
      separator_colour_q <= RST_SEPARATOR_COLOUR;
      downlight_colour_q <= RST_DOWNLIGHT_COLOUR;
      separator_style_q  <= SEP_DUAL;
      downlights_on_q    <= 1'b0;
      display_on_q       <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_HOUR_COLOUR:      hour_colour_q      <= cfg_wdata_i;
        REG_MINUTE_COLOUR:    minute_colour_q    <= cfg_wdata_i;
        REG_SEPARATOR_COLOUR: separator_colour_q <= cfg_wdata_i;
        REG_DOWNLIGHT_COLOUR: downlight_colour_q <= cfg_wdata_i;
        REG_SEPARATOR_STYLE:  separator_style_q  <= cfg_wdata_i[1:0];
        REG_DOWNLIGHTS_ON:    downlights_on_q    <= cfg_wdata_i[0];
        REG_DISPLAY_ON:       display_on_q       <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // stage handshakes
  logic   s1_valid_q, s2_valid_q, out_valid_q;
  logic   s1_ready, s2_ready, s3_ready;
  dec_t   s1_d, s1_q;
  match_t s2_d, s2_q;
  out_word_t out_d, out_q;

  assign s3_ready   = !out_valid_q || out_ready_i;
  assign s2_ready   = !s2_valid_q || s3_ready;
  assign s1_ready   = !s1_valid_q || s2_ready;
  assign in_ready_o = s1_ready;

  // stage 1: decode
  logic [14:0] seg_prod;
  logic [4:0]  hr_mod;
  logic [9:0]  tens_prod;
  logic [6:0]  tens_x10;
  logic [2:0]  tens;
  logic [10:0] idx_w;

  always_comb begin
    idx_w = 11'(in_data_i.pixel_index);
    // divide by 9 via reciprocal, exact below 512
    seg_prod = 15'(in_data_i.pixel_index) * 15'd57;
    if (in_data_i.hour_value >= 5'd24) begin
      hr_mod = in_data_i.hour_value - 5'd24;
    end else if (in_data_i.hour_value >= 5'd12) begin
      hr_mod = in_data_i.hour_value - 5'd12;
    end else begin
      hr_mod = in_data_i.hour_value;
    end
    // divide by 10 via reciprocal, exact below 64
    tens_prod = 10'(in_data_i.minute_value) * 10'd13;
    tens      = tens_prod[9:7];
    tens_x10  = 7'(tens) * 7'd10;

    s1_d.idx    = in_data_i.pixel_index;
    s1_d.seg    = seg_prod[13:9];
    s1_d.blank  = !display_on_q || (idx_w >= STRIP_LEN_W);
    s1_d.down   = idx_w >= DIGIT_LEDS_W;
    s1_d.colon  = ((separator_style_q == SEP_DUAL) &&
                   (in_data_i.pixel_index == COLON_LEFT_LED ||
                    in_data_i.pixel_index == COLON_RIGHT_LED)) ||
                  ((separator_style_q == SEP_SINGLE) &&
                   (in_data_i.pixel_index == COLON_MID_LED));
    s1_d.phase  = in_data_i.separator_phase;
    s1_d.twelve = (hr_mod == 5'd0) ? 4'd12 : hr_mod[3:0];
    s1_d.tens   = tens;
    s1_d.units  = 4'(7'(in_data_i.minute_value) - tens_x10);
  end

  // stage 2: segment match
  logic [31:0] lead_mask, hour_mask, mtens_mask, munits_mask;
  logic [3:0]  hr_ones;

  always_comb begin
    hr_ones     = (s1_q.twelve >= 4'd10) ? s1_q.twelve - 4'd10 : s1_q.twelve;
    lead_mask   = (s1_q.twelve >= 4'd10) ? digit_seg_mask(2'd0, 4'd1) : '0;
    hour_mask   = digit_seg_mask(2'd1, hr_ones);
    mtens_mask  = digit_seg_mask(2'd2, 4'(s1_q.tens));
    munits_mask = digit_seg_mask(2'd3, s1_q.units);

    s2_d.idx        = s1_q.idx;
    s2_d.blank      = s1_q.blank;
    s2_d.down       = s1_q.down;
    s2_d.colon      = s1_q.colon;
    s2_d.phase      = s1_q.phase;
    s2_d.hour_hit   = lead_mask[s1_q.seg] || hour_mask[s1_q.seg];
    s2_d.minute_hit = mtens_mask[s1_q.seg] || munits_mask[s1_q.seg];
  end

  // stage 3: colour selection
  always_comb begin
    out_d.pixel_out = s2_q.idx;
    priority if (s2_q.blank) begin
      out_d.pixel_colour = '0;
    end else if (s2_q.down) begin
      out_d.pixel_colour = downlights_on_q ? downlight_colour_q : '0;
    end else if (s2_q.colon) begin
      out_d.pixel_colour = s2_q.phase ? separator_colour_q : '0;
    end else if (s2_q.hour_hit) begin
      out_d.pixel_colour = hour_colour_q;
    end else if (s2_q.minute_hit) begin
      out_d.pixel_colour = minute_colour_q;
    end else begin
      out_d.pixel_colour = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_ready)  s1_valid_q  <= in_valid_i;
      if (s2_ready)  s2_valid_q  <= s1_valid_q;
      if (s3_ready)  out_valid_q <= s2_valid_q;
    end
  end

  // payload registers: load when the stage advances, hold otherwise
  always_ff @(posedge clk_i) begin
    if (s1_ready && in_valid_i)  s1_q  <= s1_d;
    if (s2_ready && s1_valid_q)  s2_q  <= s2_d;
    if (s3_ready && s2_valid_q)  out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `ASSERT_NEXT(a_accept_fills_s1, in_valid_i && in_ready_o, s1_valid_q)
  `ASSERT_NEXT(a_s1_holds_on_stall, s1_valid_q && !s2_ready,
               s1_valid_q && $stable(s1_q))
  `ASSERT_NEXT(a_s2_to_out_index, s2_valid_q && s3_ready,
               out_valid_o && out_data_o.pixel_out == $past(s2_q.idx))

endmodule

// ===== bench/pixel_colour_checker.sv =====
// Checker for the strip clock renderer: tracks the register writes, predicts
// the colour of every accepted pixel word and compares the output words.
// Depends on sscr_pkg for the word types, register indexes and LED constants.
module pixel_colour_checker
  import sscr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_addr_i,
  input  logic [23:0] cfg_wdata_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  in_word_t    in_data_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  out_word_t   out_data_i,
  output int          mismatch_count_o,
  output int          outstanding_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LEDS_PER_SEGMENT = 9;
  localparam logic [7:0]  UNPLACED = 8'hFF;

  // Elements lit per decimal digit, digit 9 first.
  localparam logic [9:0][6:0] DIGIT_ELEMENTS = {
    7'h6F, 7'h7F, 7'h25, 7'h7B, 7'h6B, 7'h2E, 7'h6D, 7'h5D, 7'h24, 7'h77
  };

  // Strip segment of element e at digit position p, position 3 and element 6 first.
  localparam logic [3:0][6:0][7:0] SEGMENT_PLACE = {
    8'd5, 8'd6, 8'd29, 8'd31, 8'd7, 8'd30, 8'd8,
    8'd3, 8'd26, 8'd23, 8'd25, 8'd27, 8'd24, 8'd10,
    8'd1, 8'd20, 8'd17, 8'd19, 8'd21, 8'd18, 8'd12,
    UNPLACED, 8'd15, UNPLACED, UNPLACED, 8'd14, UNPLACED, UNPLACED
  };

  logic [23:0] hour_colour;
  logic [23:0] minute_colour;
  logic [23:0] separator_colour;
  logic [23:0] downlight_colour;
  logic [1:0]  separator_style;
  logic        downlights_on;
  logic        display_on;

  out_word_t expected_pixels [$];

  function automatic bit segment_lit(input int unsigned pos, input int unsigned digit,
                                     input int unsigned seg);
    if (digit > 9) return 1'b0;
    for (int e = 0; e < 7; e++) begin
      if (DIGIT_ELEMENTS[digit][e] && SEGMENT_PLACE[pos][e] == seg) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic [23:0] predict_pixel_colour(input in_word_t w);
    int unsigned idx;
    int unsigned hr12;
    int unsigned mins;
    int unsigned seg;
    idx  = w.pixel_index;
    mins = w.minute_value;
    if (!display_on || idx >= STRIP_LENGTH) return 24'h0;
    if (idx >= DIGIT_LEDS) return downlights_on ? downlight_colour : 24'h0;
    // colon LEDs win over any digit segment they sit in
    if ((separator_style == SEP_DUAL && (idx == COLON_LEFT_LED || idx == COLON_RIGHT_LED)) ||
        (separator_style == SEP_SINGLE && idx == COLON_MID_LED))
      return w.separator_phase ? separator_colour : 24'h0;
    hr12 = w.hour_value % 12;
    if (hr12 == 0) hr12 = 12;
    seg = idx / LEDS_PER_SEGMENT;
    if (hr12 >= 10 && segment_lit(0, 1, seg)) return hour_colour;
    if (segment_lit(1, hr12 % 10, seg)) return hour_colour;
    if (segment_lit(2, mins / 10, seg)) return minute_colour;
    if (segment_lit(3, mins % 10, seg)) return minute_colour;
    return 24'h0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_word_t want;
    out_word_t seen;
    if (!rst_ni) begin
      hour_colour      = RST_HOUR_COLOUR;
      minute_colour    = RST_MINUTE_COLOUR;
      separator_colour = RST_SEPARATOR_COLOUR;
      downlight_colour = RST_DOWNLIGHT_COLOUR;
      separator_style  = SEP_DUAL;
      downlights_on    = 1'b0;
      display_on       = 1'b1;
      expected_pixels.delete();
      mismatch_count_o = 0;
      outstanding_o    = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        seen = out_data_i;
        if (expected_pixels.size() == 0) begin
          $display("%0t: unexpected word: expected none, actual pixel %0d colour %06h",
                   $time, seen.pixel_out, seen.pixel_colour);
          mismatch_count_o++;
        end else begin
          want = expected_pixels.pop_front();
          if (seen.pixel_out !== want.pixel_out) begin
            $display("%0t: pixel_out expected %0d actual %0d",
                     $time, want.pixel_out, seen.pixel_out);
            mismatch_count_o++;
          end
          if (seen.pixel_colour !== want.pixel_colour) begin
            $display("%0t: pixel_colour of pixel %0d expected %06h actual %06h",
                     $time, want.pixel_out, want.pixel_colour, seen.pixel_colour);
            mismatch_count_o++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        want.pixel_out    = in_data_i.pixel_index;
        want.pixel_colour = predict_pixel_colour(in_data_i);
        expected_pixels.push_back(want);
      end
      if (cfg_we_i) begin
        case (cfg_addr_i)
          REG_HOUR_COLOUR:      hour_colour      = cfg_wdata_i;
          REG_MINUTE_COLOUR:    minute_colour    = cfg_wdata_i;
          REG_SEPARATOR_COLOUR: separator_colour = cfg_wdata_i;
          REG_DOWNLIGHT_COLOUR: downlight_colour = cfg_wdata_i;
          REG_SEPARATOR_STYLE:  separator_style  = cfg_wdata_i[1:0];
          REG_DOWNLIGHTS_ON:    downlights_on    = cfg_wdata_i[0];
          REG_DISPLAY_ON:       display_on       = cfg_wdata_i[0];
          default: ;
        endcase
      end
      outstanding_o = expected_pixels.size();
    end
  end

endmodule

// ===== bench/seven_segment_strip_clock_render_unit_tb.sv =====
// Top of the strip clock renderer bench: clock, reset, register programming,
// pixel stimulus with random idling, and the verdict.
// Depends on sscr_pkg, the renderer RTL and pixel_colour_checker.
module seven_segment_strip_clock_render_unit_tb;
  import sscr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          CYCLE_LIMIT     = 200000;
  localparam int          PHASE_COUNT     = 8;
  localparam int          ITEMS_PER_PHASE = 219;
  localparam logic [2:0]  REG_UNUSED      = 3'd7;
  localparam logic [1:0]  SEP_NONE        = 2'd2;
  localparam logic [1:0]  SEP_SPARE       = 2'd3;

  logic        clk_i;
  logic        rst_ni      = 1'b0;
  logic        cfg_we_i    = 1'b0;
  logic [2:0]  cfg_addr_i  = '0;
  logic [23:0] cfg_wdata_i = '0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  in_word_t    in_data_i   = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  out_word_t   out_data_o;

  int mismatch_count;
  int outstanding;
  int cycle_count    = 0;
  int src_idle_pct   = 0;
  int sink_stall_pct = 0;

  seven_segment_strip_clock_render_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  pixel_colour_checker checker_i (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_addr_i       (cfg_addr_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .in_data_i        (in_data_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .out_data_i       (out_data_o),
    .mismatch_count_o (mismatch_count),
    .outstanding_o    (outstanding)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= sink_stall_pct);
  end

  // Present one word, idling first at the sender's rate; returns on the accepting edge.
  task automatic send_pixel(input logic [8:0] idx, input logic [4:0] hr,
                            input logic [5:0] mins, input logic ph);
    logic taken;
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= '{pixel_index: idx, hour_value: hr, minute_value: mins,
                    separator_phase: ph};
    // sample ready mid-cycle, where nothing moves
    do begin
      @(negedge clk_i);
      taken = in_ready_o;
      @(posedge clk_i);
    end while (!taken);
  endtask

  task automatic send_random_pixel();
    int unsigned pick;
    logic [8:0]  idx;
    logic [4:0]  hr;
    logic [5:0]  mins;
    pick = $urandom_range(99);
    if (pick < 80)      idx = 9'($urandom_range(DIGIT_LEDS - 1));
    else if (pick < 88) idx = 9'($urandom_range(STRIP_LENGTH - 1, DIGIT_LEDS));
    else if (pick < 92) begin
      case ($urandom_range(2))
        0:       idx = COLON_LEFT_LED;
        1:       idx = COLON_RIGHT_LED;
        default: idx = COLON_MID_LED;
      endcase
    end else idx = 9'($urandom_range(511));
    hr   = ($urandom_range(9) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(23));
    mins = ($urandom_range(9) == 0) ? 6'($urandom_range(63)) : 6'($urandom_range(59));
    send_pixel(idx, hr, mins, 1'($urandom));
  endtask

  // Drop valid, wait for every expected word, then let the pipeline settle.
  task automatic wait_until_idle();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (outstanding != 0) @(negedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] addr, input logic [23:0] data);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= addr;
    cfg_wdata_i <= data;
    @(posedge clk_i);
  endtask

  // Write every register; flag and style words carry random upper bits.
  task automatic program_registers(input logic [23:0] hc, input logic [23:0] mc,
                                   input logic [23:0] sc, input logic [23:0] dc,
                                   input logic [1:0] style, input logic dl_on,
                                   input logic disp_on);
    write_reg(REG_HOUR_COLOUR, hc);
    write_reg(REG_MINUTE_COLOUR, mc);
    write_reg(REG_SEPARATOR_COLOUR, sc);
    write_reg(REG_DOWNLIGHT_COLOUR, dc);
    write_reg(REG_SEPARATOR_STYLE, {22'($urandom), style});
    write_reg(REG_DOWNLIGHTS_ON, {23'($urandom), dl_on});
    write_reg(REG_DISPLAY_ON, {23'($urandom), disp_on});
    write_reg(REG_UNUSED, 24'($urandom));
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: dual colon, downlights off
    send_pixel(9'd0, 5'd0, 6'd0, 1'b0);
    send_pixel(COLON_LEFT_LED, 5'd10, 6'd30, 1'b1);
    send_pixel(COLON_LEFT_LED, 5'd10, 6'd30, 1'b0);
    send_pixel(COLON_RIGHT_LED, 5'd23, 6'd59, 1'b1);
    send_pixel(COLON_MID_LED, 5'd12, 6'd0, 1'b1);
    send_pixel(9'd126, 5'd12, 6'd0, 1'b0);
    send_pixel(9'd135, 5'd0, 6'd0, 1'b0);
    send_pixel(9'd126, 5'd9, 6'd0, 1'b0);
    send_pixel(9'd287, 5'd31, 6'd63, 1'b1);
    send_pixel(9'd288, 5'd5, 6'd5, 1'b0);
    send_pixel(9'd299, 5'd7, 6'd8, 1'b1);
    send_pixel(9'd300, 5'd11, 6'd11, 1'b1);
    send_pixel(9'd511, 5'd31, 6'd63, 1'b1);
    send_pixel(9'd243, 5'd24, 6'd60, 1'b0);
    send_pixel(9'd9, 5'd13, 6'd7, 1'b1);
    wait_until_idle();

    program_registers(RST_HOUR_COLOUR, RST_MINUTE_COLOUR, RST_SEPARATOR_COLOUR,
                      RST_DOWNLIGHT_COLOUR, SEP_SINGLE, 1'b1, 1'b1);
    send_pixel(COLON_MID_LED, 5'd0, 6'd0, 1'b1);
    send_pixel(COLON_LEFT_LED, 5'd0, 6'd0, 1'b1);
    send_pixel(9'd288, 5'd0, 6'd0, 1'b0);
    wait_until_idle();

    program_registers(RST_HOUR_COLOUR, RST_MINUTE_COLOUR, RST_SEPARATOR_COLOUR,
                      RST_DOWNLIGHT_COLOUR, SEP_SPARE, 1'b1, 1'b0);
    send_pixel(COLON_RIGHT_LED, 5'd1, 6'd2, 1'b1);
    send_pixel(9'd126, 5'd12, 6'd0, 1'b0);
    send_pixel(9'd295, 5'd0, 6'd0, 1'b0);
    wait_until_idle();

    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      case (phase)
        0: program_registers(24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom),
                             SEP_DUAL, 1'b1, 1'b1);
        1: program_registers(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
                             SEP_SINGLE, 1'b0, 1'b1);
        2: program_registers(24'h000000, 24'h000000, 24'h000000, 24'h000000,
                             SEP_NONE, 1'b1, 1'b1);
        3: program_registers(24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom),
                             SEP_SPARE, 1'b1, 1'b1);
        4: program_registers(24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom),
                             SEP_DUAL, 1'b1, 1'b0);
        5: program_registers(24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom),
                             SEP_SINGLE, 1'b1, 1'b1);
        6: program_registers(24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom),
                             SEP_DUAL, 1'b0, 1'b1);
        default: program_registers(24'($urandom), 24'($urandom), 24'($urandom),
                                   24'($urandom), SEP_NONE, 1'b1, 1'b1);
      endcase
      case (phase % 4)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 67; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 67; end
        default: begin src_idle_pct = 16; sink_stall_pct = 16; end
      endcase
      repeat (ITEMS_PER_PHASE) send_random_pixel();
      wait_until_idle();
      src_idle_pct   = 0;
      sink_stall_pct = 0;
    end

    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
